>>> rtl/core/hnt_pkg.sv
// ----------------------------------------------------------------------------
// hnt_pkg - shared types and constants of the hdlc nrzi transmit framer
// Chunk and line bit group types, hdlc constants and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package hnt_pkg;

	// parameter defaults
	localparam int TRAINING_BITS_DEF  = 24;
	localparam int RAMP_UP_BITS_DEF   = 3;
	localparam int RAMP_DOWN_BITS_DEF = 3;

	// hdlc constants
	localparam logic [7:0]  HDLC_FLAG = 8'h7E;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [2:0]  STUFF_RUN = 3'd5;

	// raw bits per chunk and worst case line bits after stuffing
	localparam int RAW_W  = 8;
	localparam int LINE_W = 10;

	// group of raw bits handed from the chunker to the coder
	typedef struct packed {
		logic [RAW_W-1:0] raw;        // bit 0 is sent first
		logic [3:0]       n;          // number of valid raw bits, 1 to 8
		logic             stuff;      // apply zero stuffing
		logic             start;      // first chunk of a frame
		logic             last_chunk; // final chunk of a frame
	} chunk_t;

	// coded line levels handed from the coder to the packer
	typedef struct packed {
		logic [LINE_W-1:0] bits;      // bit 0 is sent first, unused bits zero
		logic [3:0]        n;         // number of valid line bits
		logic              frame_end; // these are the last bits of the frame
	} line_t;

endpackage

`default_nettype wire

>>> rtl/core/hdlc_nrzi_tx_framer.sv
// ----------------------------------------------------------------------------
// hdlc_nrzi_tx_framer - hdlc transmit framer with crc, stuffing and nrzi
// Top level: start level register, chunk sequencer, coder and byte packer.
// ----------------------------------------------------------------------------
// Message bytes enter on the s_ stream, one item per byte, s_tlast on the last
// byte of a frame; NRZI line bytes leave on the m_ stream, bit 0 first, with
// m_tlast on the last line byte of the frame. The sequencer turns each held
// item into chunks of up to eight raw bits, one chunk per cycle while the
// coder takes them: one chunk for a payload byte, at frame start
// ceil((RAMP_UP_BITS + TRAINING_BITS + 8) / 8) more (5 by default), and four
// more after the last byte (fcs high, fcs low, flag, ramp down; three if
// RAMP_DOWN_BITS is 0). Each chunk becomes up to ten line bits, and the output
// register moves one line byte per cycle while m_tready allows it. A payload
// byte passes through the item register, the chunk pipeline register, the bit
// buffer and the output register. nrzi_start_level (reset 1) is written
// through cfg_wr_en/cfg_wr_data and is used at the start of the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_nrzi_tx_framer #(
	parameter int TRAINING_BITS  = hnt_pkg::TRAINING_BITS_DEF,
	parameter int RAMP_UP_BITS   = hnt_pkg::RAMP_UP_BITS_DEF,
	parameter int RAMP_DOWN_BITS = hnt_pkg::RAMP_DOWN_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data, // nrzi_start_level
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,     // data_byte
	input  wire logic       s_tlast,     // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,     // line_byte
	output logic            m_tlast      // frame_end
);
	import hnt_pkg::*;

	logic   start_level_q;
	chunk_t chunk_s2;
	logic   chunk_vld_s2;
	logic   chunk_take;
	logic   room;
	line_t  line;
	logic   line_vld;

	// start level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= 1'b1;
		end else if (cfg_wr_en) begin
			start_level_q <= cfg_wr_data;
		end
	end

	// frame sequencer and crc
	hnt_chunker #(
		.TRAINING_BITS  (TRAINING_BITS),
		.RAMP_UP_BITS   (RAMP_UP_BITS),
		.RAMP_DOWN_BITS (RAMP_DOWN_BITS)
	) u_chunker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.chunk_s2     (chunk_s2),
		.chunk_vld_s2 (chunk_vld_s2),
		.chunk_rdy    (chunk_take)
	);

	// stuffing and nrzi
	hnt_coder u_coder (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_level  (start_level_q),
		.chunk_s2     (chunk_s2),
		.chunk_vld_s2 (chunk_vld_s2),
		.chunk_take   (chunk_take),
		.room         (room),
		.line         (line),
		.line_vld     (line_vld)
	);

	// byte packer and output register
	hnt_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.line     (line),
		.line_vld (line_vld),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	// a held chunk carries one to eight raw bits
	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_vld_s2 |-> (chunk_s2.n != 4'd0) && (chunk_s2.n <= 4'd8))
		else $error("chunk with bad bit count");

	// the preamble chunk that opens a frame is never stuffed
	a_start_unstuffed: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_vld_s2 && chunk_s2.start |-> !chunk_s2.stuff)
		else $error("stuffing on frame start chunk");

	// coded bits never exceed the stuffing worst case
	a_line_len: assert property (@(posedge clk) disable iff (!arst_n)
		line_vld |-> (line.n != 4'd0) && (line.n <= 4'(LINE_W)))
		else $error("line bit count out of range");

	// a chunk not taken by the coder waits unchanged
	a_chunk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_vld_s2 && !chunk_take |=> chunk_vld_s2 && $stable(chunk_s2))
		else $error("chunk lost or changed while stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/core/hnt_chunker.sv
// ----------------------------------------------------------------------------
// hnt_chunker - frame sequencer and crc
// Holds one input item and cuts preamble, payload, fcs and tail into chunks of
// up to eight raw bits, one chunk per cycle into a pipeline register when free.
// ----------------------------------------------------------------------------
`default_nettype none

module hnt_chunker #(
	parameter int TRAINING_BITS  = hnt_pkg::TRAINING_BITS_DEF,
	parameter int RAMP_UP_BITS   = hnt_pkg::RAMP_UP_BITS_DEF,
	parameter int RAMP_DOWN_BITS = hnt_pkg::RAMP_DOWN_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,   // data_byte
	input  wire logic          s_tlast,   // last_byte
	output hnt_pkg::chunk_t    chunk_s2,
	output logic               chunk_vld_s2,
	input  wire logic          chunk_rdy
);
	import hnt_pkg::*;

	localparam int PRE_BITS = RAMP_UP_BITS + TRAINING_BITS + 8;
	localparam int PCW      = $clog2(PRE_BITS + 8);

	typedef enum logic [5:0] {
		PH_PRE    = 6'b000001,
		PH_DATA   = 6'b000010,
		PH_FCS_HI = 6'b000100,
		PH_FCS_LO = 6'b001000,
		PH_FLAG   = 6'b010000,
		PH_RDN    = 6'b100000
	} phase_t;

	logic           item_vld_q;
	logic [7:0]     data_q;
	logic           last_q;
	phase_t         phase_q;
	phase_t         phase_nx;
	logic [PCW-1:0] pre_cnt_q;
	logic           in_frame_q;
	logic [15:0]    crc_q;

	chunk_t         chunk_d;
	logic           slot_free;
	logic           fire;
	logic           accept;
	logic           item_done;
	logic           pre_done;
	logic           frame_open;
	logic [15:0]    fcs;

	// crc over eight bits, bit 0 first, msb first register
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[15] ^ d[i];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// handshake
	assign slot_free = !chunk_vld_s2 || chunk_rdy;
	assign fire      = item_vld_q && slot_free;
	assign s_tready  = !item_vld_q || (fire && item_done);
	assign accept    = s_tvalid && s_tready;
	assign fcs       = ~crc_q;

	// frame still open after this cycle's chunk
	assign frame_open = in_frame_q && !(fire && chunk_d.last_chunk);

	// chunk generation per phase
	always_comb begin
		int k;
		int rem;
		int fl;
		chunk_d   = '0;
		phase_nx  = phase_q;
		item_done = 1'b0;
		pre_done  = 1'b0;
		k         = 0;
		fl        = 0;
		rem       = PRE_BITS - int'(pre_cnt_q);
		case (phase_q)
			PH_PRE: begin
				for (int j = 0; j < 8; j++) begin
					k = int'(pre_cnt_q) + j;
					fl = k - RAMP_UP_BITS - TRAINING_BITS;
					if (k < RAMP_UP_BITS) begin
						chunk_d.raw[j] = 1'b1;
					end else if (k < RAMP_UP_BITS + TRAINING_BITS) begin
						chunk_d.raw[j] = (((k - RAMP_UP_BITS) & 1) == 0);
					end else if (fl < 8) begin
						chunk_d.raw[j] = HDLC_FLAG[3'(fl)];
					end else begin
						chunk_d.raw[j] = 1'b0;
					end
				end
				chunk_d.n     = (rem >= 8) ? 4'd8 : 4'(rem);
				chunk_d.start = (pre_cnt_q == '0);
				pre_done      = (rem <= 8);
				if (pre_done) begin
					phase_nx = PH_DATA;
				end
			end
			PH_DATA: begin
				chunk_d.raw   = data_q;
				chunk_d.n     = 4'd8;
				chunk_d.stuff = 1'b1;
				if (last_q) begin
					phase_nx = PH_FCS_HI;
				end else begin
					item_done = 1'b1;
				end
			end
			PH_FCS_HI: begin
				for (int j = 0; j < 8; j++) begin
					chunk_d.raw[j] = fcs[4'(15 - j)];
				end
				chunk_d.n     = 4'd8;
				chunk_d.stuff = 1'b1;
				phase_nx      = PH_FCS_LO;
			end
			PH_FCS_LO: begin
				for (int j = 0; j < 8; j++) begin
					chunk_d.raw[j] = fcs[4'(7 - j)];
				end
				chunk_d.n     = 4'd8;
				chunk_d.stuff = 1'b1;
				phase_nx      = PH_FLAG;
			end
			PH_FLAG: begin
				chunk_d.raw = HDLC_FLAG;
				chunk_d.n   = 4'd8;
				if (RAMP_DOWN_BITS == 0) begin
					chunk_d.last_chunk = 1'b1;
					item_done          = 1'b1;
				end else begin
					phase_nx = PH_RDN;
				end
			end
			PH_RDN: begin
				chunk_d.raw        = '0;
				chunk_d.n          = 4'(RAMP_DOWN_BITS);
				chunk_d.last_chunk = 1'b1;
				item_done          = 1'b1;
			end
			default: begin
				phase_nx = PH_DATA;
			end
		endcase
	end

	// item register and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			phase_q    <= PH_PRE;
			pre_cnt_q  <= '0;
			in_frame_q <= 1'b0;
			crc_q      <= CRC_INIT;
		end else if (accept) begin
			// a new item replaces the one that just finished
			item_vld_q <= 1'b1;
			in_frame_q <= 1'b1;
			pre_cnt_q  <= '0;
			if (frame_open) begin
				phase_q <= PH_DATA;
				if (fire && (phase_q == PH_DATA)) begin
					crc_q <= crc_byte(crc_q, data_q);
				end
			end else begin
				phase_q <= PH_PRE;
				crc_q   <= CRC_INIT;
			end
		end else if (fire) begin
			phase_q <= phase_nx;
			if (phase_q == PH_PRE) begin
				pre_cnt_q <= pre_cnt_q + PCW'(8);
			end
			if (phase_q == PH_DATA) begin
				crc_q <= crc_byte(crc_q, data_q);
			end
			if (item_done) begin
				item_vld_q <= 1'b0;
			end
			if (chunk_d.last_chunk) begin
				in_frame_q <= 1'b0;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= s_tdata;
			last_q <= s_tlast;
		end
	end

	// chunk pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_vld_s2 <= 1'b0;
		end else if (fire) begin
			chunk_vld_s2 <= 1'b1;
		end else if (chunk_rdy) begin
			chunk_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			chunk_s2 <= chunk_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hnt_coder.sv
// ----------------------------------------------------------------------------
// hnt_coder - zero stuffing and nrzi line coding
// Turns one chunk of raw bits into line levels, inserting a zero after five
// ones where stuffing applies, and keeps the ones run and line level.
// ----------------------------------------------------------------------------
`default_nettype none

module hnt_coder (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start_level,
	input  wire hnt_pkg::chunk_t  chunk_s2,
	input  wire logic             chunk_vld_s2,
	output logic                  chunk_take,
	input  wire logic             room,
	output hnt_pkg::line_t        line,
	output logic                  line_vld
);
	import hnt_pkg::*;

	logic       level_q;
	logic [2:0] run_q;
	logic       level_end;
	logic [2:0] run_end;

	assign chunk_take = chunk_vld_s2 && room;
	assign line_vld   = chunk_take;

	// stuffing and nrzi over the chunk, bit 0 first
	always_comb begin
		logic       lvl;
		logic [2:0] run;
		logic [3:0] pos;
		logic       b;
		lvl  = chunk_s2.start ? start_level : level_q;
		run  = chunk_s2.start ? 3'd0 : run_q;
		pos  = 4'd0;
		b    = 1'b0;
		line = '0;
		for (int j = 0; j < RAW_W; j++) begin
			if (4'(j) < chunk_s2.n) begin
				b = chunk_s2.raw[j];
				if (!b) begin
					lvl = ~lvl;
				end
				line.bits[pos] = lvl;
				pos = pos + 4'd1;
				if (chunk_s2.stuff) begin
					if (b) begin
						run = run + 3'd1;
						if (run >= STUFF_RUN) begin
							lvl = ~lvl;
							line.bits[pos] = lvl;
							pos = pos + 4'd1;
							run = 3'd0;
						end
					end else begin
						run = 3'd0;
					end
				end
			end
		end
		line.n         = pos;
		line.frame_end = chunk_s2.last_chunk;
		level_end      = lvl;
		run_end        = run;
	end

	// coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b1;
			run_q   <= 3'd0;
		end else if (chunk_take) begin
			level_q <= level_end;
			run_q   <= run_end;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hnt_packer.sv
// ----------------------------------------------------------------------------
// hnt_packer - line bit packer and output register
// Collects line levels in a short bit buffer, moves one line byte a cycle into
// the output register when free, padding and marking a frame's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hnt_packer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hnt_pkg::line_t   line,
	input  wire logic             line_vld,
	output logic                  room,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,  // line_byte
	output logic                  m_tlast   // frame_end
);
	import hnt_pkg::*;

	localparam int BUF_W = 7 + LINE_W;
	localparam int CW    = $clog2(BUF_W + 1);

	logic [BUF_W-1:0] buf_q;
	logic [CW-1:0]    cnt_q;
	logic             flush_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;
	logic             out_vld_q;

	logic             out_free;
	logic             drain;
	logic             last_drain;
	logic [BUF_W-1:0] buf_sh;
	logic [CW-1:0]    cnt_sh;
	logic             flush_sh;
	logic [BUF_W-1:0] buf_nx;
	logic [CW-1:0]    cnt_nx;
	logic             flush_nx;

	// drain one byte when full or when the frame is being flushed
	assign out_free   = !out_vld_q || m_tready;
	assign drain      = out_free && ((cnt_q >= CW'(8)) || (flush_q && (cnt_q != '0)));
	assign last_drain = drain && flush_q && (cnt_q <= CW'(8));
	assign buf_sh     = drain ? (buf_q >> 8) : buf_q;
	assign cnt_sh     = drain ? ((cnt_q >= CW'(8)) ? (cnt_q - CW'(8)) : '0) : cnt_q;
	assign flush_sh   = flush_q && !last_drain;
	assign room       = (cnt_sh <= CW'(7)) && !flush_sh;

	// append new line bits above the ones still held
	always_comb begin
		buf_nx   = buf_sh;
		cnt_nx   = cnt_sh;
		flush_nx = flush_sh;
		if (line_vld) begin
			buf_nx   = buf_sh | (BUF_W'(line.bits) << cnt_sh[2:0]);
			cnt_nx   = cnt_sh + CW'(line.n);
			flush_nx = flush_sh || line.frame_end;
		end
	end

	// bit buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			cnt_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			buf_q   <= buf_nx;
			cnt_q   <= cnt_nx;
			flush_q <= flush_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (drain) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_data_q <= buf_q[7:0];
			out_last_q <= last_drain;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> dv/hdlc_nrzi_tx_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdlc_nrzi_tx_framer_tb - self-checking bench for the hdlc nrzi transmit framer
// Streams message bytes in frames, predicts every NRZI line byte (preamble,
// crc, zero stuffing, end flag, padding) in a local model of the framer and
// checks each line byte and its frame end mark in order, under random idling
// on both streams at three settings (one with none) and both start levels.
// ----------------------------------------------------------------------------

module hdlc_nrzi_tx_framer_tb;

	import hnt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 30;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       frame_end;
	} line_byte_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       s_tvalid    = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata     = 8'h00; // data_byte
	logic       s_tlast     = 1'b0;  // last_byte
	logic       m_tvalid;
	logic       m_tready    = 1'b0;
	logic [7:0] m_tdata;             // line_byte
	logic       m_tlast;             // frame_end

	// framer model state
	logic        start_level = 1'b1;
	logic [15:0] crc_acc;
	int          ones_seen;
	logic        line_lvl;
	logic [7:0]  pack_acc;
	int          pack_fill;
	bit          framing = 1'b0;
	line_byte_t  pending_line_q[$];

	int send_idle_pct = 15;
	int recv_idle_pct = 50;
	int items_sent    = 0;
	int frames_sent   = 0;
	int bytes_checked = 0;
	int mismatches    = 0;
	int cycle_count   = 0;

	hdlc_nrzi_tx_framer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	// clock
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d line bytes outstanding",
				$time, cycle_count, pending_line_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// nrzi code one line bit and pack it, bit 0 first
	function automatic void put_level(input logic b);
		if (!b)
			line_lvl = ~line_lvl;
		pack_acc[pack_fill] = line_lvl;
		pack_fill++;
		if (pack_fill == 8) begin
			pending_line_q.push_back('{line_byte: pack_acc, frame_end: 1'b0});
			pack_acc  = 8'h00;
			pack_fill = 0;
		end
	endfunction

	// zero insertion after a run of ones
	function automatic void put_stuffed(input logic b);
		put_level(b);
		if (b) begin
			ones_seen++;
			if (ones_seen >= STUFF_RUN) begin
				put_level(1'b0);
				ones_seen = 0;
			end
		end else begin
			ones_seen = 0;
		end
	endfunction

	function automatic void put_flag();
		for (int i = 0; i < 8; i++)
			put_level(HDLC_FLAG[i]);
	endfunction

	// line bytes caused by one message byte
	function automatic void code_frame_byte(input logic [7:0] data, input logic last);
		logic [15:0] fcs;
		logic        fb;
		// preamble on the first byte of a frame
		if (!framing) begin
			framing   = 1'b1;
			crc_acc   = CRC_INIT;
			ones_seen = 0;
			pack_acc  = 8'h00;
			pack_fill = 0;
			line_lvl  = start_level;
			for (int i = 0; i < RAMP_UP_BITS_DEF; i++)
				put_level(1'b1);
			for (int i = 0; i < TRAINING_BITS_DEF; i++)
				put_level((i % 2) == 0);
			put_flag();
		end
		// payload bits, lsb first, crc over sent order
		for (int i = 0; i < 8; i++) begin
			fb      = crc_acc[15] ^ data[i];
			crc_acc = crc_acc << 1;
			if (fb)
				crc_acc = crc_acc ^ CRC_POLY;
			put_stuffed(data[i]);
		end
		// fcs, end flag, ramp down and flush
		if (last) begin
			fcs = ~crc_acc;
			for (int i = 0; i < 16; i++)
				put_stuffed(fcs[15 - i]);
			put_flag();
			for (int i = 0; i < RAMP_DOWN_BITS_DEF; i++)
				put_level(1'b0);
			if (pack_fill != 0) begin
				pending_line_q.push_back('{line_byte: pack_acc, frame_end: 1'b0});
				pack_acc  = 8'h00;
				pack_fill = 0;
			end
			pending_line_q[pending_line_q.size() - 1].frame_end = 1'b1;
			framing   = 1'b0;
			ones_seen = 0;
			frames_sent++;
		end
	endfunction

	// line byte checker
	always @(posedge clk) begin
		line_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (pending_line_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected line byte, expected none, got %02h last %0b",
						$time, m_tdata, m_tlast);
			end else begin
				want = pending_line_q.pop_front();
				if (m_tdata !== want.line_byte) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: line byte mismatch, expected %02h, got %02h",
							$time, want.line_byte, m_tdata);
				end
				if (m_tlast !== want.frame_end) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: frame end mismatch, expected %0b, got %0b",
							$time, want.frame_end, m_tlast);
				end
			end
		end
	end

	// present one message byte and wait for it to be taken
	task automatic send_item(input logic [7:0] data, input logic last);
		int gap;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		code_frame_byte(data, last);
		items_sent++;
	endtask

	// stop sending and let every line byte come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_line_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_level(input logic level);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= level;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		start_level = level;
	endtask

	// byte values biased toward runs of ones and the flag pattern
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'hFF;
			1: return 8'h00;
			2: return HDLC_FLAG;
			3: return 8'hFF ^ (8'h01 << $urandom_range(7));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic test_single_byte_frames();
		write_start_level(1'b1);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(HDLC_FLAG, 1'b1);
		settle();
	endtask

	task automatic test_stuffing_runs();
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h1F, 1'b0);
		send_item(8'hF8, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h00, 1'b1);
		settle();
	endtask

	task automatic test_start_level_low();
		write_start_level(1'b0);
		send_item(8'h55, 1'b1);
		send_item(8'hAA, 1'b0);
		send_item(8'h80, 1'b1);
		send_item(8'hFE, 1'b1);
		settle();
	endtask

	// random frames, mostly short, a few long
	task automatic test_random_frames(input int budget, input int send_pct,
		input int recv_pct, input logic level, input bit hold_mid);
		int  len;
		int  sent;
		bit  held;
		sent = 0;
		held = 1'b0;
		write_start_level(level);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (sent < budget) begin
			len = ($urandom_range(99) < 10) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				send_item(pick_byte(), k == len - 1);
				sent++;
				// hold the sender mid frame until the output has caught up
				if (hold_mid && !held && len > 2 && k == len / 2) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending_line_q.size() != 0);
					held = 1'b1;
				end
			end
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_byte_frames();
		test_stuffing_runs();
		test_start_level_low();
		test_random_frames(130, 15, 50, 1'b1, 1'b1);
		test_random_frames(130, 50, 15, 1'b0, 1'b0);
		test_random_frames(140, 0, 0, 1'b1, 1'b0);

		$display("%0d message bytes in %0d frames, %0d line bytes checked, %0d errors",
			items_sent, frames_sent, bytes_checked, mismatches);
		$display("covered both start levels, one byte and long frames, stuffing runs, stalls");
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/hnt_pkg.sv
rtl/core/hnt_chunker.sv
rtl/core/hnt_coder.sv
rtl/core/hnt_packer.sv
rtl/core/hdlc_nrzi_tx_framer.sv
dv/hdlc_nrzi_tx_framer_tb.sv
